// ===== rtl/core/max_reduce_image_downscaler_top_defines.svh =====
// assertion macros shared by the checker
`ifndef MAX_REDUCE_IMAGE_DOWNSCALER_TOP_DEFINES_SVH
`define MAX_REDUCE_IMAGE_DOWNSCALER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define MRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrd check failed");

// next-cycle implication, off during reset
`define MRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrd check failed");

// what must hold in the cycle after reset
`define MRD_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("mrd reset check failed");

`endif

// ===== rtl/core/mrd_pkg.sv =====
package mrd_pkg;

  localparam int CFG_BITS       = 13;
  localparam int CFG_INDEX_BITS = 2;
  localparam int PORT_BITS      = 16;
  localparam int NUM_CH         = 4;
  localparam int Q_DEPTH        = 4;
  localparam int OUT_DEPTH      = 4;

  localparam int DEF_MAX_WIDTH    = 4096;
  localparam int DEF_MAX_HEIGHT   = 4096;
  localparam int DEF_CHANNEL_BITS = 16;

  localparam logic [CFG_BITS-1:0] DEF_SIZE = 13'd4096;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_DEST_WIDTH    = 2'd2,
    REG_DEST_HEIGHT   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic box_start;
    logic col_end;
    logic band_end;
    logic last_col;
    logic last_row;
    logic first_row;
  } item_ctl_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } res_flags_t;

endpackage

// ===== rtl/core/max_reduce_image_downscaler_top.sv =====
// Max-pooling image downscaler. Source pixels enter in raster order through push/full,
// one per clock unless full, and each destination pixel (per-channel maximum over its box)
// leaves the result queue through empty/pop after the source pixel that closes its box is
// accepted, with row_end and frame_end marking row and frame boundaries. A front stage
// tracks box edges with integer error accumulators; a back stage keeps the running box
// maximum and a row buffer of per-column maxima, updated by a two-stage read-modify-write
// with forwarding that sets the one-pixel-per-clock rate. Any configuration write restarts
// the frame; write sizes only while no pixel is in flight. The row buffer is not cleared
// after reset and needs no clearing pass, since each band's first row fills it before use.
module max_reduce_image_downscaler_top #(
  parameter int MAX_WIDTH    = mrd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = mrd_pkg::DEF_MAX_HEIGHT,
  parameter int CHANNEL_BITS = mrd_pkg::DEF_CHANNEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mrd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mrd_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic [mrd_pkg::PORT_BITS-1:0]      red_in,
  input  logic [mrd_pkg::PORT_BITS-1:0]      green_in,
  input  logic [mrd_pkg::PORT_BITS-1:0]      blue_in,
  input  logic [mrd_pkg::PORT_BITS-1:0]      alpha_in,
  output logic                               empty,
  input  logic                               pop,
  output logic [mrd_pkg::PORT_BITS-1:0]      red_out,
  output logic [mrd_pkg::PORT_BITS-1:0]      green_out,
  output logic [mrd_pkg::PORT_BITS-1:0]      blue_out,
  output logic [mrd_pkg::PORT_BITS-1:0]      alpha_out,
  output logic                               row_end,
  output logic                               frame_end
);
  import mrd_pkg::*;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ITEM_W  = $bits(item_ctl_t) + COL_W + NUM_CH * CHANNEL_BITS;
  localparam int RES_W   = $bits(res_flags_t) + NUM_CH * PORT_BITS;
  localparam int LVL_W   = $clog2(OUT_DEPTH + 1);
  localparam int QLVL_W  = $clog2(Q_DEPTH + 1);

  logic                                accept;
  item_ctl_t                           f_ctl;
  logic [COL_W-1:0]                    f_col;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] in_pix;
  logic                                q_full;
  logic                                q_empty;
  logic                                q_pop;
  logic [ITEM_W-1:0]                   q_rdata;
  logic [QLVL_W-1:0]                   q_level;
  item_ctl_t                           q_ctl;
  logic [COL_W-1:0]                    q_col;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] q_pix;
  logic [LVL_W-1:0]                    out_level;
  logic                                out_push;
  logic [NUM_CH-1:0][PORT_BITS-1:0]    b_pix;
  res_flags_t                          b_flags;
  logic [RES_W-1:0]                    o_rdata;
  logic [NUM_CH-1:0][PORT_BITS-1:0]    o_pix;
  res_flags_t                          o_flags;
  logic                                o_full;

  assign full   = q_full;
  assign accept = push && !q_full;

  assign in_pix[0] = CHANNEL_BITS'(red_in);
  assign in_pix[1] = CHANNEL_BITS'(green_in);
  assign in_pix[2] = CHANNEL_BITS'(blue_in);
  assign in_pix[3] = CHANNEL_BITS'(alpha_in);

  mrd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .ctl         (f_ctl),
    .dst_col_out (f_col)
  );

  mrd_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (Q_DEPTH)
  ) u_item_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata ({f_ctl, f_col, in_pix}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .level (q_level)
  );

  assign {q_ctl, q_col, q_pix} = q_rdata;

  mrd_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_ctl     (q_ctl),
    .q_col     (q_col),
    .q_pix     (q_pix),
    .q_pop     (q_pop),
    .out_level (out_level),
    .out_push  (out_push),
    .out_pix   (b_pix),
    .out_flags (b_flags)
  );

  mrd_queue #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata ({b_flags, b_pix}),
    .full  (o_full),
    .pop   (pop),
    .rdata (o_rdata),
    .empty (empty),
    .level (out_level)
  );

  assign {o_flags, o_pix} = o_rdata;

  assign red_out   = o_pix[0];
  assign green_out = o_pix[1];
  assign blue_out  = o_pix[2];
  assign alpha_out = o_pix[3];
  assign row_end   = o_flags.row_end;
  assign frame_end = o_flags.frame_end;

  // sink for the unused queue level and full outputs
  logic unused_levels;
  assign unused_levels = ^{q_level, o_full};
endmodule

// ===== rtl/core/mrd_queue.sv =====
module mrd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == LVL_W'(DEPTH));
  assign empty   = (count == '0);
  assign level   = count;
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + LVL_W'(1);
        2'b01:   count <= count - LVL_W'(1);
        default: count <= count;
      endcase
    end
  end
endmodule

// ===== rtl/core/mrd_front.sv =====
module mrd_front #(
  parameter int MAX_WIDTH  = mrd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mrd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mrd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mrd_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic                              accept,
  output mrd_pkg::item_ctl_t                ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]      dst_col_out
);
  import mrd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int CMP_A = (WD_W > HT_W) ? WD_W : HT_W;
  localparam int CMP_W = (CMP_A > CFG_BITS) ? CMP_A : CFG_BITS;

  function automatic logic [CMP_W-1:0] eff_size(input logic [CFG_BITS-1:0] r,
                                                input logic [CMP_W-1:0] lim);
    logic [CMP_W-1:0] v;
    v = CMP_W'(r);
    if (v == '0) begin
      eff_size = CMP_W'(1);
    end else if (v > lim) begin
      eff_size = lim;
    end else begin
      eff_size = v;
    end
  endfunction

  logic [CFG_BITS-1:0] source_width;
  logic [CFG_BITS-1:0] source_height;
  logic [CFG_BITS-1:0] dest_width;
  logic [CFG_BITS-1:0] dest_height;

  logic [COL_W-1:0] src_col;
  logic [ROW_W-1:0] src_row;
  logic [COL_W-1:0] dst_col;
  logic [WD_W-1:0]  col_error;
  logic [HT_W-1:0]  row_error;
  logic             band_first_row;

  logic [CMP_W-1:0] sw_full;
  logic [CMP_W-1:0] sh_full;
  logic [CMP_W-1:0] dw_full;
  logic [CMP_W-1:0] dh_full;
  logic [WD_W-1:0]  sw;
  logic [WD_W-1:0]  dw;
  logic [HT_W-1:0]  sh;
  logic [HT_W-1:0]  dh;
  logic [WD_W-1:0]  tc;
  logic [HT_W-1:0]  tr;
  logic             last_col;
  logic             last_row;
  logic             col_end;
  logic             band_end;

  // effective sizes: zero acts as one, source saturates, no magnification
  assign sw_full = eff_size(source_width, CMP_W'(MAX_WIDTH));
  assign sh_full = eff_size(source_height, CMP_W'(MAX_HEIGHT));
  assign dw_full = eff_size(dest_width, sw_full);
  assign dh_full = eff_size(dest_height, sh_full);
  assign sw      = sw_full[WD_W-1:0];
  assign sh      = sh_full[HT_W-1:0];
  assign dw      = dw_full[WD_W-1:0];
  assign dh      = dh_full[HT_W-1:0];

  assign last_col = (WD_W'(src_col) + WD_W'(1)) >= sw;
  assign last_row = (HT_W'(src_row) + HT_W'(1)) >= sh;
  assign tc = (col_error >= dw) ? col_error - dw : col_error + (sw - dw);
  assign tr = (row_error >= dh) ? row_error - dh : row_error + (sh - dh);
  assign col_end  = (tc < dw) || last_col;
  assign band_end = (tr < dh) || last_row;

  always_comb begin
    ctl.box_start = (col_error < dw);
    ctl.col_end   = col_end;
    ctl.band_end  = band_end;
    ctl.last_col  = last_col;
    ctl.last_row  = last_row;
    ctl.first_row = band_first_row;
  end

  assign dst_col_out = dst_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width   <= DEF_SIZE;
      source_height  <= DEF_SIZE;
      dest_width     <= DEF_SIZE;
      dest_height    <= DEF_SIZE;
      src_col        <= '0;
      src_row        <= '0;
      dst_col        <= '0;
      col_error      <= '0;
      row_error      <= '0;
      band_first_row <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_DEST_WIDTH:    dest_width    <= cfg_data;
        REG_DEST_HEIGHT:   dest_height   <= cfg_data;
        default: ;
      endcase
      // any write restarts the frame
      src_col        <= '0;
      src_row        <= '0;
      dst_col        <= '0;
      col_error      <= '0;
      row_error      <= '0;
      band_first_row <= 1'b1;
    end else if (accept) begin
      if (col_end) begin
        dst_col <= last_col ? '0 : dst_col + COL_W'(1);
      end
      if (last_col) begin
        col_error      <= '0;
        src_col        <= '0;
        row_error      <= last_row ? '0 : tr;
        band_first_row <= band_end;
        src_row        <= last_row ? '0 : src_row + ROW_W'(1);
      end else begin
        col_error <= tc;
        src_col   <= src_col + COL_W'(1);
      end
    end
  end
endmodule

// ===== rtl/core/mrd_back.sv =====
module mrd_back #(
  parameter int MAX_WIDTH    = mrd_pkg::DEF_MAX_WIDTH,
  parameter int CHANNEL_BITS = mrd_pkg::DEF_CHANNEL_BITS
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              q_empty,
  input  mrd_pkg::item_ctl_t                                q_ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0]                      q_col,
  input  logic [mrd_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]      q_pix,
  output logic                                              q_pop,
  input  logic [$clog2(mrd_pkg::OUT_DEPTH+1)-1:0]           out_level,
  output logic                                              out_push,
  output logic [mrd_pkg::NUM_CH-1:0][mrd_pkg::PORT_BITS-1:0] out_pix,
  output mrd_pkg::res_flags_t                               out_flags
);
  import mrd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LVL_W = $clog2(OUT_DEPTH + 1);
  localparam int BUF_W = NUM_CH * CHANNEL_BITS;

  logic [BUF_W-1:0] row_buf [MAX_WIDTH];

  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] span;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] span_next;

  // read-modify-write stage
  logic                                b_valid;
  item_ctl_t                           b_ctl;
  logic [COL_W-1:0]                    b_addr;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] b_span;
  logic [BUF_W-1:0]                    rd_data;
  logic                                fwd;
  logic [BUF_W-1:0]                    fwd_data;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] prev;
  logic [NUM_CH-1:0][CHANNEL_BITS-1:0] merged;
  logic                                b_out;
  logic                                go;

  assign b_out = b_valid && b_ctl.band_end;
  assign go    = !q_empty && ((LVL_W + 1)'(out_level) + (LVL_W + 1)'(b_out)
                              < (LVL_W + 1)'(OUT_DEPTH));
  assign q_pop = go;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      span_next[c] = (q_ctl.box_start || q_pix[c] > span[c]) ? q_pix[c] : span[c];
    end
  end

  // write-back of the previous cycle is forwarded when the same column is read
  assign prev = fwd ? fwd_data : rd_data;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      merged[c]  = (!b_ctl.first_row && prev[c] > b_span[c]) ? prev[c] : b_span[c];
      out_pix[c] = PORT_BITS'(merged[c]);
    end
  end

  assign out_push            = b_out;
  assign out_flags.row_end   = b_ctl.last_col;
  assign out_flags.frame_end = b_ctl.last_col && b_ctl.last_row;

  always_ff @(posedge clk) begin
    if (b_valid) begin
      row_buf[b_addr] <= merged;
    end
    if (go && q_ctl.col_end) begin
      rd_data <= row_buf[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      span   <= span_next;
      b_span <= span_next;
      b_ctl  <= q_ctl;
      b_addr <= q_col;
    end
    fwd      <= b_valid && (b_addr == q_col);
    fwd_data <= merged;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= go && q_ctl.col_end;
    end
  end
endmodule

// ===== rtl/core/mrd_checker.sv =====
`include "max_reduce_image_downscaler_top_defines.svh"

module mrd_checker (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic pop,
  input logic empty,
  input logic row_end,
  input logic frame_end
);
  // transactions accepted in minus results taken out
  logic [31:0] balance;

  always_ff @(posedge clk) begin
    if (rst) begin
      balance <= '0;
    end else begin
      case ({push && !full, pop && !empty})
        2'b10:   balance <= balance + 32'd1;
        2'b01:   balance <= balance - 32'd1;
        default: balance <= balance;
      endcase
    end
  end

  `MRD_ASSERT_RESET(a_reset_idle, empty && !full)
  `MRD_ASSERT_NOW(a_no_extra_result, pop && !empty, balance != 32'd0)
  `MRD_ASSERT_NOW(a_frame_closes_row, !empty && frame_end, row_end)
  `MRD_ASSERT_NEXT(a_result_held, !empty && !pop, !empty)
endmodule

bind max_reduce_image_downscaler_top mrd_checker u_mrd_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .pop       (pop),
  .empty     (empty),
  .row_end   (row_end),
  .frame_end (frame_end)
);

// ===== tb/sv/max_reduce_image_downscaler_top_tb.sv =====
module max_reduce_image_downscaler_top_tb;
  import mrd_pkg::*;

  localparam int FRAME_W_MAX = DEF_MAX_WIDTH;
  localparam int FRAME_H_MAX = DEF_MAX_HEIGHT;
  localparam int RANDOM_PIXELS = 1350;

  typedef logic [PORT_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } pixel_t;

  typedef struct packed {
    pixel_t px;
    logic   row_end;
    logic   frame_end;
  } dest_pixel_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;
  logic                      push;
  logic                      full;
  chan_t                     red_in;
  chan_t                     green_in;
  chan_t                     blue_in;
  chan_t                     alpha_in;
  logic                      empty;
  logic                      pop;
  chan_t                     red_out;
  chan_t                     green_out;
  chan_t                     blue_out;
  chan_t                     alpha_out;
  logic                      row_end;
  logic                      frame_end;

  max_reduce_image_downscaler_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .empty     (empty),
    .pop       (pop),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

  // downscaler state mirror
  logic [CFG_BITS-1:0] size_reg [4];
  chan_t               band_max [FRAME_W_MAX][NUM_CH];
  chan_t               span_max [NUM_CH];
  int unsigned         src_col;
  int unsigned         src_row;
  int unsigned         dst_col;
  int unsigned         col_slack;
  int unsigned         row_slack;
  bit                  band_first;

  pixel_t      source_pixels [$];
  dest_pixel_t expected_pixels [$];

  int unsigned pixels_in;
  int unsigned pixels_out;
  int unsigned settings_used;
  int unsigned errors;
  int unsigned in_gap;
  int unsigned out_gap;
  bit          in_taken;
  bit          out_taken;
  bit          steady_in;
  bit          steady_out;

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic int unsigned next_slack(input int unsigned t, input int unsigned big,
                                             input int unsigned tiny);
    return (t >= tiny) ? t - tiny : t + big - tiny;
  endfunction

  function automatic void restart_frame();
    foreach (span_max[c]) span_max[c] = '0;
    src_col    = 0;
    src_row    = 0;
    dst_col    = 0;
    col_slack  = 0;
    row_slack  = 0;
    band_first = 1'b1;
  endfunction

  function automatic void downscale_pixel(input pixel_t p);
    int unsigned sw;
    int unsigned sh;
    int unsigned dw;
    int unsigned dh;
    int unsigned tc;
    int unsigned tr;
    int unsigned d;
    bit          last_col;
    bit          last_row;
    bit          box_start;
    bit          col_end;
    bit          band_end;
    chan_t       px [NUM_CH];
    chan_t       res [NUM_CH];
    chan_t       m;
    dest_pixel_t r;
    sw = clamp_size(size_reg[REG_SOURCE_WIDTH], FRAME_W_MAX);
    sh = clamp_size(size_reg[REG_SOURCE_HEIGHT], FRAME_H_MAX);
    dw = clamp_size(size_reg[REG_DEST_WIDTH], sw);
    dh = clamp_size(size_reg[REG_DEST_HEIGHT], sh);
    px = '{p.red, p.green, p.blue, p.alpha};
    last_col  = (src_col + 1 >= sw);
    last_row  = (src_row + 1 >= sh);
    box_start = (col_slack < dw);
    tc = next_slack(col_slack, sw, dw);
    tr = next_slack(row_slack, sh, dh);
    col_end  = (tc < dw) || last_col;
    band_end = (tr < dh) || last_row;
    for (int c = 0; c < NUM_CH; c++) begin
      if (box_start || px[c] > span_max[c]) span_max[c] = px[c];
    end
    if (col_end) begin
      d = (dst_col < FRAME_W_MAX) ? dst_col : FRAME_W_MAX - 1;
      for (int c = 0; c < NUM_CH; c++) begin
        m = span_max[c];
        if (!band_first && band_max[d][c] > m) m = band_max[d][c];
        band_max[d][c] = m;
        res[c] = m;
      end
      if (band_end) begin
        r.px.red    = res[0];
        r.px.green  = res[1];
        r.px.blue   = res[2];
        r.px.alpha  = res[3];
        r.row_end   = last_col;
        r.frame_end = last_col && last_row;
        expected_pixels.push_back(r);
      end
      dst_col = last_col ? 0 : (dst_col + 1) & 12'hFFF;
    end
    if (last_col) begin
      col_slack  = 0;
      src_col    = 0;
      row_slack  = last_row ? 0 : tr;
      band_first = band_end;
      src_row    = last_row ? 0 : (src_row + 1) & 12'hFFF;
    end else begin
      col_slack = tc;
      src_col   = (src_col + 1) & 12'hFFF;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic chan_t random_chan();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return chan_t'($urandom_range(0, 3));
      default: return chan_t'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.red   = random_chan();
    p.green = random_chan();
    p.blue  = random_chan();
    p.alpha = random_chan();
    return p;
  endfunction

  task automatic check_field(input string field, input chan_t want, input chan_t got);
    if (got !== want) begin
      errors++;
      if (errors <= 200)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // wait until the block has nothing in flight
  task automatic settle();
    while (source_pixels.size() != 0 || expected_pixels.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_size(input cfg_reg_t idx, input int unsigned val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_BITS'(val);
    size_reg[idx] = CFG_BITS'(val);
    restart_frame();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                           input int unsigned dw, input int unsigned dh);
    write_size(REG_SOURCE_WIDTH, sw);
    write_size(REG_SOURCE_HEIGHT, sh);
    write_size(REG_DEST_WIDTH, dw);
    write_size(REG_DEST_HEIGHT, dh);
    settings_used++;
  endtask

  task automatic queue_pixel(input chan_t r, input chan_t g, input chan_t b, input chan_t a);
    source_pixels.push_back('{r, g, b, a});
  endtask

  task automatic feed_random(input int unsigned count, input bit pause_mid);
    for (int unsigned i = 0; i < count; i++) begin
      if (pause_mid && i == count / 2) settle();
      source_pixels.push_back(random_pixel());
    end
  endtask

  function automatic int unsigned random_src_size(input int unsigned common_max);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, common_max);
    if (r < 9) return $urandom_range(common_max + 1, 40);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 4096;
      2: return 8191;
      default: return $urandom_range(41, 4096);
    endcase
  endfunction

  function automatic int unsigned random_dst_size(input int unsigned src_eff);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return src_eff + $urandom_range(1, 5);
      default: return $urandom_range(1, src_eff);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // source side
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_gap = steady_in ? 0 : pick_gap();
      end
      if (in_gap != 0) begin
        in_gap--;
        push <= 1'b0;
      end else if (source_pixels.size() != 0) begin
        push     <= 1'b1;
        red_in   <= source_pixels[0].red;
        green_in <= source_pixels[0].green;
        blue_in  <= source_pixels[0].blue;
        alpha_in <= source_pixels[0].alpha;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_gap = steady_out ? 0 : pick_gap();
      end
      if (out_gap != 0) begin
        out_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch
    dest_pixel_t want;
    if (!rst) begin
      if (push && !full) begin
        in_taken = 1'b1;
        pixels_in++;
        downscale_pixel(source_pixels.pop_front());
      end
      if (pop && !empty) begin
        out_taken = 1'b1;
        pixels_out++;
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= 200)
            $display("%0t: unexpected transaction, expected none, actual %0h %0h %0h %0h %b %b",
                     $time, red_out, green_out, blue_out, alpha_out, row_end, frame_end);
        end else begin
          want = expected_pixels.pop_front();
          check_field("red_out", want.px.red, red_out);
          check_field("green_out", want.px.green, green_out);
          check_field("blue_out", want.px.blue, blue_out);
          check_field("alpha_out", want.px.alpha, alpha_out);
          check_field("row_end", chan_t'(want.row_end), chan_t'(row_end));
          check_field("frame_end", chan_t'(want.frame_end), chan_t'(frame_end));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned sw;
    int unsigned sh;
    int unsigned dw;
    int unsigned dh;
    int unsigned count;
    int unsigned random_fed;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    push      = 1'b0;
    pop       = 1'b0;
    red_in    = '0;
    green_in  = '0;
    blue_in   = '0;
    alpha_in  = '0;
    in_gap    = 0;
    out_gap   = 0;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    steady_in = 1'b0;
    steady_out = 1'b0;
    pixels_in = 0;
    pixels_out = 0;
    settings_used = 1;
    errors = 0;
    random_fed = 0;
    foreach (size_reg[i]) size_reg[i] = DEF_SIZE;
    restart_frame();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset sizes: every pixel is its own box
    queue_pixel('0, '0, '0, '0);
    queue_pixel('1, '1, '1, '1);
    queue_pixel(16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0);
    settle();

    // oversize source, zero height, magnification asked
    set_sizes(8191, 0, 8191, 0);
    queue_pixel(16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE);
    queue_pixel(16'h0001, 16'h8000, 16'hFFFE, 16'h7FFF);
    settle();

    // single column, tallest frame
    set_sizes(1, 4096, 1, 4096);
    queue_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
    queue_pixel('1, '0, '1, '0);
    queue_pixel('0, '1, '0, '1);
    settle();

    // uneven boxes, sender paused until all results are out mid-frame
    set_sizes(3, 2, 2, 1);
    queue_pixel(16'h0010, 16'h0020, 16'h0030, 16'h0040);
    queue_pixel(16'h0011, 16'h0001, 16'h0031, 16'h0001);
    queue_pixel(16'h0002, 16'h0022, 16'h0002, 16'h0042);
    settle();
    queue_pixel(16'h0003, 16'h0003, 16'h0033, 16'h0003);
    queue_pixel(16'h0013, 16'h0023, 16'h0003, 16'h0043);
    queue_pixel('1, 16'h0000, 16'h0000, 16'h0001);
    settle();

    // whole frame into one pixel, each channel peaks at a different spot
    set_sizes(2, 2, 1, 1);
    queue_pixel('1, 16'h0000, 16'h0001, 16'h0002);
    queue_pixel(16'h0000, '1, 16'h0003, 16'h0000);
    queue_pixel(16'h0001, 16'h0002, '1, 16'h0000);
    queue_pixel(16'h0000, 16'h0000, 16'h0000, '1);
    settle();

    // one-pixel frames
    set_sizes(1, 1, 1, 1);
    queue_pixel(16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0);
    queue_pixel(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    settle();

    while (random_fed < RANDOM_PIXELS) begin
      sw = random_src_size(10);
      sh = random_src_size(8);
      dw = random_dst_size(clamp_size(sw, FRAME_W_MAX));
      dh = random_dst_size(clamp_size(sh, FRAME_H_MAX));
      set_sizes(sw, sh, dw, dh);
      count = clamp_size(sw, FRAME_W_MAX) * clamp_size(sh, FRAME_H_MAX) * $urandom_range(1, 3);
      if (count > 300) count = $urandom_range(1, 150);
      else if ($urandom_range(0, 9) == 0) count = $urandom_range(1, count);
      if (count > RANDOM_PIXELS - random_fed) count = RANDOM_PIXELS - random_fed;
      steady_in  = ($urandom_range(0, 5) == 0);
      steady_out = ($urandom_range(0, 5) == 0);
      feed_random(count, $urandom_range(0, 9) == 0);
      random_fed += count;
      settle();
    end

    $display("fed %0d source pixels, checked %0d destination pixels", pixels_in, pixels_out);
    $display("over %0d frame size settings, degenerate and oversize sizes included",
             settings_used);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mrd_pkg.sv
rtl/core/mrd_queue.sv
rtl/core/mrd_front.sv
rtl/core/mrd_back.sv
rtl/core/max_reduce_image_downscaler_top.sv
rtl/core/mrd_checker.sv
tb/sv/max_reduce_image_downscaler_top_tb.sv
